>>> sv/fsq_pkg.sv
package fsq_pkg;

   localparam int unsigned NCOL   = 5;
   localparam int unsigned NTERM  = 3;
   localparam int unsigned NPART  = 4;

   localparam int unsigned IN_W   = 54;
   localparam int unsigned LIMB_W = 51;
   localparam int unsigned OUT_W  = 52;

   // multiplier operand split: x up to 60 bits, y is a plain input limb
   localparam int unsigned X_W    = 60;
   localparam int unsigned XL_W   = 30;
   localparam int unsigned YL_W   = 27;
   localparam int unsigned PP_W   = XL_W + YL_W;
   localparam int unsigned PROD_W = X_W + IN_W;

   // column sum of three products, doubled, with headroom for the carry in
   localparam int unsigned COL_W  = PROD_W + 4;
   localparam int unsigned K_W    = COL_W - LIMB_W;
   localparam int unsigned FOLD   = 19;
   localparam int unsigned WRAP_W = K_W + 6;

   localparam int unsigned MUL_STAGES = 3;
   localparam int unsigned RED_STAGES = NCOL + 3;

   localparam logic CMD_SQUARE = 1'b0;
   localparam logic CMD_DOUBLE = 1'b1;

   localparam int unsigned PP_LL = 0;
   localparam int unsigned PP_LH = 1;
   localparam int unsigned PP_HL = 2;
   localparam int unsigned PP_HH = 3;

   // operands of the three products of each column: x = limb[X_SEL] * X_MUL, y = limb[Y_SEL]
   localparam int unsigned X_SEL [NCOL][NTERM] = '{
      '{0, 1, 2}, '{0, 2, 3}, '{0, 1, 3}, '{0, 1, 4}, '{0, 1, 2}};
   localparam int unsigned X_MUL [NCOL][NTERM] = '{
      '{1, 38, 38}, '{2, 38, 19}, '{2, 1, 38}, '{2, 2, 19}, '{2, 2, 1}};
   localparam int unsigned Y_SEL [NCOL][NTERM] = '{
      '{0, 4, 3}, '{1, 4, 3}, '{2, 1, 4}, '{3, 2, 4}, '{4, 3, 2}};

   typedef logic [IN_W-1:0]  in_limb_type;
   typedef logic [OUT_W-1:0] out_limb_type;

   typedef out_limb_type [NCOL-1:0] out_limbs_type;

   typedef struct packed {
      logic                         command;
      in_limb_type [NCOL-1:0]       limb;
   } req_type;

   typedef struct packed {
      logic                                   command;
      logic [NCOL-1:0][NTERM-1:0][PROD_W-1:0] prod;
   } prod_bus_type;

endpackage

>>> sv/fsq_req_if.sv
interface fsq_req_if import fsq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              command;
   logic [IN_W-1:0]   in_limb0;
   logic [IN_W-1:0]   in_limb1;
   logic [IN_W-1:0]   in_limb2;
   logic [IN_W-1:0]   in_limb3;
   logic [IN_W-1:0]   in_limb4;

   modport source (
      output valid, command, in_limb0, in_limb1, in_limb2, in_limb3, in_limb4,
      input  ready
   );
   modport sink (
      input  valid, command, in_limb0, in_limb1, in_limb2, in_limb3, in_limb4,
      output ready
   );
endinterface

>>> sv/fsq_rsp_if.sv
interface fsq_rsp_if import fsq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OUT_W-1:0]  out_limb0;
   logic [OUT_W-1:0]  out_limb1;
   logic [OUT_W-1:0]  out_limb2;
   logic [OUT_W-1:0]  out_limb3;
   logic [OUT_W-1:0]  out_limb4;

   modport source (
      output valid, out_limb0, out_limb1, out_limb2, out_limb3, out_limb4,
      input  ready
   );
   modport sink (
      input  valid, out_limb0, out_limb1, out_limb2, out_limb3, out_limb4,
      output ready
   );
endinterface

>>> sv/fsq_mul.sv
module fsq_mul import fsq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  req_type       in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output prod_bus_type  out_data
);

   typedef struct packed {
      logic                                 command;
      logic [NCOL-1:0][NTERM-1:0][X_W-1:0]  x;
      logic [NCOL-1:0][NTERM-1:0][IN_W-1:0] y;
   } opnd_type;

   typedef struct packed {
      logic                                             command;
      logic [NCOL-1:0][NTERM-1:0][NPART-1:0][PP_W-1:0]  pp;
   } pp_type;

   localparam int unsigned OPND_STG = 0;
   localparam int unsigned PP_STG   = 1;
   localparam int unsigned LAST     = MUL_STAGES - 1;

   opnd_type      opnd_ff, opnd_in;
   pp_type        pp_ff, pp_in;
   prod_bus_type  prod_ff, prod_in;

   logic vld_ff [MUL_STAGES];
   logic vld_in [MUL_STAGES];
   logic load   [MUL_STAGES];

   // per-stage valid and load, bubbles collapse under back pressure
   for (genvar s = 0; s < MUL_STAGES; s++) begin : g_ctl
      logic up_valid;
      if (s == 0) begin : g_first
         assign up_valid = in_valid;
      end else begin : g_next
         assign up_valid = vld_ff[s-1];
      end
      if (s == LAST) begin : g_tail
         assign load[s] = !vld_ff[s] || out_ready;
      end else begin : g_body
         assign load[s] = !vld_ff[s] || load[s+1];
      end
      assign vld_in[s] = load[s] ? up_valid : vld_ff[s];
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_in[s];
         end
      end
   end

   // operand forming, constant factors are shift-adds
   always_comb begin
      opnd_in.command = in_data.command;
      for (int c = 0; c < NCOL; c++) begin
         for (int t = 0; t < NTERM; t++) begin
            opnd_in.x[c][t] = X_W'(in_data.limb[X_SEL[c][t]]) * X_W'(X_MUL[c][t]);
            opnd_in.y[c][t] = in_data.limb[Y_SEL[c][t]];
         end
      end
   end

   // partial products, 30 by 27 bits each
   always_comb begin
      logic [XL_W-1:0]      xl;
      logic [X_W-XL_W-1:0]  xh;
      logic [YL_W-1:0]      yl;
      logic [IN_W-YL_W-1:0] yh;
      pp_in.command = opnd_ff.command;
      for (int c = 0; c < NCOL; c++) begin
         for (int t = 0; t < NTERM; t++) begin
            xl = opnd_ff.x[c][t][XL_W-1:0];
            xh = opnd_ff.x[c][t][X_W-1:XL_W];
            yl = opnd_ff.y[c][t][YL_W-1:0];
            yh = opnd_ff.y[c][t][IN_W-1:YL_W];
            pp_in.pp[c][t][PP_LL] = PP_W'(xl) * PP_W'(yl);
            pp_in.pp[c][t][PP_LH] = PP_W'(xl) * PP_W'(yh);
            pp_in.pp[c][t][PP_HL] = PP_W'(xh) * PP_W'(yl);
            pp_in.pp[c][t][PP_HH] = PP_W'(xh) * PP_W'(yh);
         end
      end
   end

   // recombine partials into full products
   always_comb begin
      prod_in.command = pp_ff.command;
      for (int c = 0; c < NCOL; c++) begin
         for (int t = 0; t < NTERM; t++) begin
            prod_in.prod[c][t] = PROD_W'(pp_ff.pp[c][t][PP_LL])
                               + (PROD_W'(pp_ff.pp[c][t][PP_LH]) << YL_W)
                               + (PROD_W'(pp_ff.pp[c][t][PP_HL]) << XL_W)
                               + (PROD_W'(pp_ff.pp[c][t][PP_HH]) << (XL_W + YL_W));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[OPND_STG]) begin
         opnd_ff <= opnd_in;
      end
      if (load[PP_STG]) begin
         pp_ff <= pp_in;
      end
      if (load[LAST]) begin
         prod_ff <= prod_in;
      end
   end

   assign in_ready  = load[0];
   assign out_valid = vld_ff[LAST];
   assign out_data  = prod_ff;

`ifndef NO_ASSERTIONS
   a_mul_empty_tail_accepts: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[LAST] |-> in_ready)
      else $error("multiplier refuses a beat with an empty product stage");

   a_mul_pp_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[PP_STG] && !load[PP_STG] |=> vld_ff[PP_STG] && $stable(pp_ff))
      else $error("stalled partial product stage lost its contents");

   a_mul_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_data))
      else $error("stalled product beat changed before it was taken");
`endif

endmodule

>>> sv/fsq_reduce.sv
module fsq_reduce import fsq_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  prod_bus_type   in_data,
   output logic           out_valid,
   input  logic           out_ready,
   output out_limbs_type  out_data
);

   typedef struct packed {
      logic [NCOL-1:0][COL_W-1:0] col;
      out_limbs_type              limb;
      logic [K_W-1:0]             k;
   } red_type;

   localparam int unsigned LAST     = RED_STAGES - 1;
   localparam int unsigned WRAP_STG = NCOL + 1;

   red_type st_ff  [RED_STAGES];
   red_type st_in  [RED_STAGES];
   logic    vld_ff [RED_STAGES];
   logic    vld_in [RED_STAGES];
   logic    load   [RED_STAGES];

   for (genvar s = 0; s < RED_STAGES; s++) begin : g_stg
      logic up_valid;
      if (s == 0) begin : g_first
         assign up_valid = in_valid;
      end else begin : g_next
         assign up_valid = vld_ff[s-1];
      end
      if (s == LAST) begin : g_tail
         assign load[s] = !vld_ff[s] || out_ready;
      end else begin : g_body
         assign load[s] = !vld_ff[s] || load[s+1];
      end
      assign vld_in[s] = load[s] ? up_valid : vld_ff[s];

      if (s == 0) begin : g_col
         // column sums, doubled when the command asks for the doubled square
         always_comb begin
            logic [COL_W-1:0] sum;
            st_in[s] = '0;
            for (int c = 0; c < NCOL; c++) begin
               sum = COL_W'(in_data.prod[c][0]) + COL_W'(in_data.prod[c][1])
                   + COL_W'(in_data.prod[c][2]);
               st_in[s].col[c] = (in_data.command == CMD_DOUBLE) ? (sum << 1) : sum;
            end
         end
      end else if (s <= NCOL) begin : g_carry
         // one limb of the carry chain
         logic [COL_W-1:0] t;
         always_comb begin
            t = st_ff[s-1].col[s-1] + COL_W'(st_ff[s-1].k);
            st_in[s] = st_ff[s-1];
            st_in[s].limb[s-1] = OUT_W'(t[LIMB_W-1:0]);
            st_in[s].k = K_W'(t >> LIMB_W);
         end
      end else if (s == WRAP_STG) begin : g_wrap
         // carry out of the top limb re-enters limb 0 times 19
         logic [WRAP_W-1:0] t;
         always_comb begin
            t = WRAP_W'(st_ff[s-1].k) * WRAP_W'(FOLD) + WRAP_W'(st_ff[s-1].limb[0]);
            st_in[s] = st_ff[s-1];
            st_in[s].limb[0] = OUT_W'(t[LIMB_W-1:0]);
            st_in[s].k = K_W'(t >> LIMB_W);
         end
      end else begin : g_final
         logic [LIMB_W:0] t;
         always_comb begin
            t = (LIMB_W + 1)'(st_ff[s-1].limb[1]) + (LIMB_W + 1)'(st_ff[s-1].k);
            st_in[s] = st_ff[s-1];
            st_in[s].limb[1] = OUT_W'(t[LIMB_W-1:0]);
            st_in[s].limb[2] = st_ff[s-1].limb[2] + OUT_W'(t[LIMB_W]);
            st_in[s].k = '0;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_in[s];
         end
         if (load[s]) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   assign in_ready  = load[0];
   assign out_valid = vld_ff[LAST];
   assign out_data  = st_ff[LAST].limb;

`ifndef NO_ASSERTIONS
   a_red_limb_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] |->
         (st_ff[LAST].limb[0] >> LIMB_W) == '0 && (st_ff[LAST].limb[1] >> LIMB_W) == '0 &&
         (st_ff[LAST].limb[3] >> LIMB_W) == '0 && (st_ff[LAST].limb[4] >> LIMB_W) == '0 &&
         st_ff[LAST].limb[2] <= (OUT_W'(1) << LIMB_W))
      else $error("result limb out of its reduced range");

   a_red_empty_tail_accepts: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[LAST] |-> in_ready)
      else $error("reduction refuses a beat with an empty output stage");

   a_red_wrap_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[WRAP_STG] && !load[WRAP_STG] |=> vld_ff[WRAP_STG] && $stable(st_ff[WRAP_STG]))
      else $error("stalled wrap stage lost its contents");
`endif

endmodule

>>> sv/field25519_square.sv
// Squares an element of GF(2^255-19) held as five radix 2^51 limbs, or doubles the
// square when command is set, and returns five partly reduced limbs (limb 2 may hold
// one extra carry). Fully pipelined: one request beat can be accepted every cycle
// while the response side takes results, so new beats enter before earlier ones
// finish. The depth is three multiplier stages (operand forming, sixty 30x27-bit
// partial products, product recombination) plus eight reduction stages (column
// sums, five carry steps, the times-19 wrap and the final carry). Every stage has
// its own valid bit, so under back pressure empty stages still fill and no beat is
// lost or repeated. No state is kept between items.
module field25519_square import fsq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   fsq_req_if.sink    req_ch,
   fsq_rsp_if.source  rsp_ch
);

   req_type        req_data;
   prod_bus_type   prod_data;
   logic           prod_valid;
   logic           prod_ready;
   out_limbs_type  rsp_data;

   assign req_data.command = req_ch.command;
   assign req_data.limb[0] = req_ch.in_limb0;
   assign req_data.limb[1] = req_ch.in_limb1;
   assign req_data.limb[2] = req_ch.in_limb2;
   assign req_data.limb[3] = req_ch.in_limb3;
   assign req_data.limb[4] = req_ch.in_limb4;

   fsq_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_data   (req_data),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod_data)
   );

   fsq_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_data   (prod_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_data)
   );

   assign rsp_ch.out_limb0 = rsp_data[0];
   assign rsp_ch.out_limb1 = rsp_data[1];
   assign rsp_ch.out_limb2 = rsp_data[2];
   assign rsp_ch.out_limb3 = rsp_data[3];
   assign rsp_ch.out_limb4 = rsp_data[4];

endmodule
